@@ rtl/soa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package soa_pkg;

  // Fixed geometry of one handle: slab number above a six-bit slot number.
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned MAX_SLOTS   = 64;
  localparam int unsigned CNT_W       = 7;
  localparam logic [6:0]  RH_NIL      = 7'h7F;
  localparam logic [6:0]  OPS_RESET   = 7'd64;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RS_OK        = 2'd0,
    RS_NO_SLAB   = 2'd1,
    RS_BAD_HANDLE = 2'd2,
    RS_NOT_ALLOC = 2'd3
  } res_status_e;

  typedef enum logic [1:0] {
    LS_EMPTY   = 2'd0,
    LS_PARTIAL = 2'd1,
    LS_FULL    = 2'd2
  } lst_e;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_SELECT,
    FS_TAKE,
    FS_LINK,
    FS_FREE,
    FS_DECIDE,
    FS_UNLINK,
    FS_PUSH,
    FS_RELEASE,
    FS_DONE
  } fsm_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LATCH,
    CMD_SELECT,
    CMD_TAKE,
    CMD_LINK,
    CMD_FREE,
    CMD_DECIDE,
    CMD_UNLINK,
    CMD_PUSH,
    CMD_RELEASE,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [9:0] object_handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] granted_handle;
    logic [1:0] slab_condition;
    logic [4:0] released_count;
  } out_word_t;

  typedef struct packed {
    logic sel_none;
    logic take_fail;
    logic take_recycled;
    logic free_fail;
    logic move_needed;
    logic rel_more;
    logic out_busy;
  } dp_status_t;

  // Effective slot count of a slab: zero acts as one, large values saturate.
  function automatic logic [6:0] used_slots(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > 7'(MAX_SLOTS)) begin
      r = 7'(MAX_SLOTS);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/soa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module soa_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/soa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module soa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire soa_pkg::op_e       op_i,
  input  wire soa_pkg::dp_status_t stat_i,
  output logic                    in_ready_o,
  output soa_pkg::cmd_e           cmd_o
);

  import soa_pkg::*;

  fsm_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_ALLOC:   state_d = FS_SELECT;
            OP_FREE:    state_d = FS_FREE;
            OP_RELEASE: state_d = FS_RELEASE;
            default:    state_d = FS_DONE;
          endcase
        end
      end
      FS_SELECT:  state_d = stat_i.sel_none ? FS_DONE : FS_TAKE;
      FS_TAKE: begin
        if (stat_i.take_fail) begin
          state_d = FS_DONE;
        end else if (stat_i.take_recycled) begin
          state_d = FS_LINK;
        end else begin
          state_d = FS_DECIDE;
        end
      end
      FS_LINK:    state_d = FS_DECIDE;
      FS_FREE:    state_d = stat_i.free_fail ? FS_DONE : FS_DECIDE;
      FS_DECIDE:  state_d = stat_i.move_needed ? FS_UNLINK : FS_DONE;
      FS_UNLINK:  state_d = FS_PUSH;
      FS_PUSH:    state_d = FS_DONE;
      FS_RELEASE: state_d = stat_i.rel_more ? FS_RELEASE : FS_DONE;
      FS_DONE:    state_d = stat_i.out_busy ? FS_DONE : FS_IDLE;
      default:    state_d = FS_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = CMD_NOP;
    case (state_q)
      FS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = CMD_LATCH;
        end
      end
      FS_SELECT:  cmd_o = CMD_SELECT;
      FS_TAKE:    cmd_o = CMD_TAKE;
      FS_LINK:    cmd_o = CMD_LINK;
      FS_FREE:    cmd_o = CMD_FREE;
      FS_DECIDE:  cmd_o = CMD_DECIDE;
      FS_UNLINK:  cmd_o = CMD_UNLINK;
      FS_PUSH:    cmd_o = CMD_PUSH;
      FS_RELEASE: cmd_o = CMD_RELEASE;
      FS_DONE:    cmd_o = stat_i.out_busy ? CMD_NOP : CMD_EMIT;
      default:    cmd_o = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/soa_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module soa_dp #(
  parameter int unsigned NUM_SLABS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire soa_pkg::cmd_e       cmd_i,
  input  wire soa_pkg::in_word_t   in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [6:0]          cfg_data_i,
  input  wire logic                out_ready_i,
  output soa_pkg::dp_status_t      stat_o,
  output logic                     out_valid_o,
  output soa_pkg::out_word_t       out_data_o
);

  import soa_pkg::*;

  localparam int unsigned SlabW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int unsigned LinkW = SlabW + 1;
  localparam int unsigned RamDepth = NUM_SLABS * MAX_SLOTS;
  localparam int unsigned RamAw = (RamDepth > 1) ? $clog2(RamDepth) : 1;
  localparam int unsigned RelW = $clog2(NUM_SLABS + 1);
  localparam logic [LinkW-1:0] NilLink = {LinkW{1'b1}};

  // Per-slab bookkeeping.
  logic              active_q [NUM_SLABS], active_d [NUM_SLABS];
  lst_e              lstate_q [NUM_SLABS], lstate_d [NUM_SLABS];
  logic [CNT_W-1:0]  fcnt_q   [NUM_SLABS], fcnt_d   [NUM_SLABS];
  logic [CNT_W-1:0]  fresh_q  [NUM_SLABS], fresh_d  [NUM_SLABS];
  logic [CNT_W-1:0]  rh_q     [NUM_SLABS], rh_d     [NUM_SLABS];
  logic [MAX_SLOTS-1:0] amap_q [NUM_SLABS], amap_d  [NUM_SLABS];
  logic [LinkW-1:0]  prev_q   [NUM_SLABS], prev_d   [NUM_SLABS];
  logic [LinkW-1:0]  next_q   [NUM_SLABS], next_d   [NUM_SLABS];
  logic [LinkW-1:0]  head_q   [3],         head_d   [3];
  logic [6:0]        ops_q, ops_d;
  logic [RelW-1:0]   rel_q, rel_d;
  logic              out_valid_q, out_valid_d;

  // Working registers of the current request.
  logic [SlabW-1:0]  sel_q, sel_d;
  lst_e              to_q, to_d;
  op_e               op_q, op_d;
  logic [9:0]        hnd_q, hnd_d;
  out_word_t         res_q, res_d;
  out_word_t         out_q, out_d;

  // Recycled-slot link memory.
  logic              ram_we;
  logic [RamAw-1:0]  ram_waddr, ram_raddr;
  logic [CNT_W-1:0]  ram_wdata, ram_rdata;

  soa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (RamDepth)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [6:0]       used;
  logic             idle_found;
  logic [SlabW-1:0] idle_idx;
  logic [3:0]       h_slab;
  logic [SLOT_W-1:0] h_slot;
  logic [SlabW-1:0] h_idx;
  logic             h_bad, h_dbl;
  logic [SLOT_W-1:0] take_slot;
  logic [LinkW-1:0] cur_p, cur_n, rel_s, push_h;
  logic             mv;
  lst_e             tgt;

  assign used = used_slots(ops_q);

  // Lowest inactive slab.
  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int i = NUM_SLABS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        idle_found = 1'b1;
        idle_idx   = SlabW'(i);
      end
    end
  end

  // Handle decode for a free request.
  assign h_slab = hnd_q[9:6];
  assign h_slot = hnd_q[5:0];
  assign h_idx  = SlabW'(h_slab);
  assign h_bad  = (int'(h_slab) >= NUM_SLABS) || !active_q[h_idx] ||
                  ({1'b0, h_slot} >= used);
  assign h_dbl  = !amap_q[h_idx][h_slot];

  assign take_slot = (rh_q[sel_q] < 7'(MAX_SLOTS)) ? rh_q[sel_q][SLOT_W-1:0]
                                                   : fresh_q[sel_q][SLOT_W-1:0];
  assign cur_p  = prev_q[sel_q];
  assign cur_n  = next_q[sel_q];
  assign rel_s  = head_q[LS_EMPTY];
  assign push_h = head_q[to_q];

  // Target list after an allocate or a free.
  always_comb begin
    mv  = 1'b0;
    tgt = lstate_q[sel_q];
    if (op_q == OP_ALLOC) begin
      if (fcnt_q[sel_q] == '0) begin
        mv  = 1'b1;
        tgt = LS_FULL;
      end else if (lstate_q[sel_q] == LS_EMPTY) begin
        mv  = 1'b1;
        tgt = LS_PARTIAL;
      end
    end else begin
      if (fcnt_q[sel_q] >= used) begin
        mv  = 1'b1;
        tgt = LS_EMPTY;
      end else if (lstate_q[sel_q] == LS_FULL) begin
        mv  = 1'b1;
        tgt = LS_PARTIAL;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    stat_o.sel_none      = !(head_q[LS_PARTIAL] < NUM_SLABS) &&
                           !(head_q[LS_EMPTY] < NUM_SLABS) && !idle_found;
    stat_o.take_fail     = (fcnt_q[sel_q] == '0);
    stat_o.take_recycled = (rh_q[sel_q] < 7'(MAX_SLOTS));
    stat_o.free_fail     = h_bad || h_dbl;
    stat_o.move_needed   = mv;
    stat_o.rel_more      = (rel_s < NUM_SLABS) && (rel_q < NUM_SLABS);
    stat_o.out_busy      = out_valid_q && !out_ready_i;
  end

  // Memory ports.
  assign ram_we    = (cmd_i == CMD_FREE) && !h_bad && !h_dbl;
  assign ram_waddr = RamAw'({h_idx, h_slot});
  assign ram_wdata = rh_q[h_idx];
  assign ram_raddr = RamAw'({sel_q, take_slot});

  // Next-state logic of the whole datapath.
  always_comb begin
    active_d    = active_q;
    lstate_d    = lstate_q;
    fcnt_d      = fcnt_q;
    fresh_d     = fresh_q;
    rh_d        = rh_q;
    amap_d      = amap_q;
    prev_d      = prev_q;
    next_d      = next_q;
    head_d      = head_q;
    ops_d       = ops_q;
    rel_d       = rel_q;
    out_valid_d = out_valid_q;
    sel_d       = sel_q;
    to_d        = to_q;
    op_d        = op_q;
    hnd_d       = hnd_q;
    res_d       = res_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      // A new size puts the pool back into its reset layout.
      ops_d = cfg_data_i;
      for (int i = 0; i < NUM_SLABS; i++) begin
        active_d[i] = (i == 0);
        lstate_d[i] = LS_EMPTY;
        fcnt_d[i]   = (i == 0) ? used_slots(cfg_data_i) : '0;
        fresh_d[i]  = '0;
        rh_d[i]     = RH_NIL;
        amap_d[i]   = '0;
        prev_d[i]   = NilLink;
        next_d[i]   = NilLink;
      end
      head_d[LS_EMPTY]   = '0;
      head_d[LS_PARTIAL] = NilLink;
      head_d[LS_FULL]    = NilLink;
    end else begin
      case (cmd_i)
        CMD_LATCH: begin
          op_d  = op_e'(in_data_i.operation);
          hnd_d = in_data_i.object_handle;
          res_d = '0;
          rel_d = '0;
        end
        CMD_SELECT: begin
          if (head_q[LS_PARTIAL] < NUM_SLABS) begin
            sel_d = head_q[LS_PARTIAL][SlabW-1:0];
          end else if (head_q[LS_EMPTY] < NUM_SLABS) begin
            sel_d = head_q[LS_EMPTY][SlabW-1:0];
          end else if (idle_found) begin
            sel_d              = idle_idx;
            active_d[idle_idx] = 1'b1;
            lstate_d[idle_idx] = LS_EMPTY;
            fcnt_d[idle_idx]   = used;
            fresh_d[idle_idx]  = '0;
            rh_d[idle_idx]     = RH_NIL;
            amap_d[idle_idx]   = '0;
            prev_d[idle_idx]   = NilLink;
            next_d[idle_idx]   = NilLink;
          end else begin
            res_d.status = RS_NO_SLAB;
          end
        end
        CMD_TAKE: begin
          if (fcnt_q[sel_q] == '0) begin
            res_d.status = RS_NO_SLAB;
          end else begin
            if (!(rh_q[sel_q] < 7'(MAX_SLOTS))) begin
              fresh_d[sel_q] = fresh_q[sel_q] + 7'd1;
            end
            amap_d[sel_q][take_slot] = 1'b1;
            fcnt_d[sel_q]            = fcnt_q[sel_q] - 7'd1;
            res_d.granted_handle     = 10'({sel_q, take_slot});
          end
        end
        CMD_LINK: begin
          rh_d[sel_q] = ram_rdata;
        end
        CMD_FREE: begin
          if (h_bad) begin
            res_d.status = RS_BAD_HANDLE;
          end else if (h_dbl) begin
            res_d.status = RS_NOT_ALLOC;
          end else begin
            amap_d[h_idx][h_slot] = 1'b0;
            rh_d[h_idx]           = 7'(h_slot);
            fcnt_d[h_idx]         = fcnt_q[h_idx] + 7'd1;
            sel_d                 = h_idx;
          end
        end
        CMD_DECIDE: begin
          to_d                 = tgt;
          res_d.slab_condition = tgt;
        end
        CMD_UNLINK: begin
          if (cur_p < NUM_SLABS) begin
            next_d[cur_p[SlabW-1:0]] = cur_n;
          end
          if (cur_n < NUM_SLABS) begin
            prev_d[cur_n[SlabW-1:0]] = cur_p;
          end
          if (head_q[lstate_q[sel_q]] == LinkW'(sel_q)) begin
            head_d[lstate_q[sel_q]] = cur_n;
          end
          prev_d[sel_q] = NilLink;
          next_d[sel_q] = NilLink;
        end
        CMD_PUSH: begin
          if (push_h < NUM_SLABS) begin
            prev_d[push_h[SlabW-1:0]] = LinkW'(sel_q);
          end
          next_d[sel_q]   = push_h;
          prev_d[sel_q]   = NilLink;
          head_d[to_q]    = LinkW'(sel_q);
          lstate_d[sel_q] = to_q;
        end
        CMD_RELEASE: begin
          // Retire the head of the empty list.
          if ((rel_s < NUM_SLABS) && (rel_q < NUM_SLABS)) begin
            if (prev_q[rel_s[SlabW-1:0]] < NUM_SLABS) begin
              next_d[prev_q[rel_s[SlabW-1:0]][SlabW-1:0]] = next_q[rel_s[SlabW-1:0]];
            end
            if (next_q[rel_s[SlabW-1:0]] < NUM_SLABS) begin
              prev_d[next_q[rel_s[SlabW-1:0]][SlabW-1:0]] = prev_q[rel_s[SlabW-1:0]];
            end
            head_d[LS_EMPTY]             = next_q[rel_s[SlabW-1:0]];
            prev_d[rel_s[SlabW-1:0]]     = NilLink;
            next_d[rel_s[SlabW-1:0]]     = NilLink;
            active_d[rel_s[SlabW-1:0]]   = 1'b0;
            lstate_d[rel_s[SlabW-1:0]]   = LS_EMPTY;
            rh_d[rel_s[SlabW-1:0]]       = RH_NIL;
            amap_d[rel_s[SlabW-1:0]]     = '0;
            rel_d                        = rel_q + RelW'(1);
          end
        end
        CMD_EMIT: begin
          out_d                = res_q;
          out_d.released_count = 5'(rel_q);
          out_valid_d          = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLABS; i++) begin
        active_q[i] <= (i == 0);
        lstate_q[i] <= LS_EMPTY;
        fcnt_q[i]   <= (i == 0) ? used_slots(OPS_RESET) : '0;
        fresh_q[i]  <= '0;
        rh_q[i]     <= RH_NIL;
        amap_q[i]   <= '0;
        prev_q[i]   <= NilLink;
        next_q[i]   <= NilLink;
      end
      head_q[LS_EMPTY]   <= '0;
      head_q[LS_PARTIAL] <= NilLink;
      head_q[LS_FULL]    <= NilLink;
      ops_q              <= OPS_RESET;
      rel_q              <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      active_q    <= active_d;
      lstate_q    <= lstate_d;
      fcnt_q      <= fcnt_d;
      fresh_q     <= fresh_d;
      rh_q        <= rh_d;
      amap_q      <= amap_d;
      prev_q      <= prev_d;
      next_q      <= next_d;
      head_q      <= head_d;
      ops_q       <= ops_d;
      rel_q       <= rel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request payload registers.
  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    to_q  <= to_d;
    op_q  <= op_d;
    hnd_q <= hnd_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/slab_object_allocator.sv @@
// Allocate: select, take, link (recycled slot), decide, unlink and push (list move), done;
// free: free, decide, unlink and push, done; release per empty slab; failures end early.
// Throughput: one word at a time; the next word is taken in the idle cycle after the result.
// A result word waits in an output register while the next word is accepted.
// Reset (rst_ni low, asynchronous): slab 0 active and empty, size 64, output idle.
// The recycled-slot link memory is not cleared; entries are written before use.
`timescale 1ns / 1ps
`default_nettype none

module slab_object_allocator #(
  parameter int unsigned NUM_SLABS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire soa_pkg::in_word_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output soa_pkg::out_word_t     out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [6:0]        cfg_data_i
);

  import soa_pkg::*;

  cmd_e       cmd;
  dp_status_t stat;

  // Sequencer.
  soa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_e'(in_data_i.operation)),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // Slab tables, lists and result registers.
  soa_dp #(
    .NUM_SLABS (NUM_SLABS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/soa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module soa_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire soa_pkg::in_word_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire soa_pkg::out_word_t out_data_o
);

  import soa_pkg::*;

  // A pending result word holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // The block is busy right after it takes a word.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("word accepted back to back");

  // Failed requests carry no handle.
  a_fail_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != RS_OK) |->
      out_data_o.granted_handle == '0 && out_data_o.slab_condition == '0)
    else $error("failed request carries a handle");

  // A release reports no handle and no slab state.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.released_count != '0) |->
      out_data_o.granted_handle == '0 && out_data_o.slab_condition == '0 &&
      out_data_o.status == RS_OK)
    else $error("release word mixed with allocate fields");

  // Slab condition never takes the unused code.
  a_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.slab_condition != 2'd3)
    else $error("bad slab condition");

endmodule

bind slab_object_allocator soa_checker u_soa_checker (.*);

`default_nettype wire
